// ===== rtl/mdnsam_pkg.sv =====
// Shared types, constants and byte tables for the mDNS IPv4 answer matcher.
`default_nettype none

package mdnsam_pkg;

    // Size of the queried name store.
    localparam int MAX_NAME_BYTES = 32;
    localparam int NAME_IDX_W     = (MAX_NAME_BYTES > 1) ? $clog2(MAX_NAME_BYTES) : 1;

    // Fixed field widths of the requests and results.
    localparam int BYTE_W   = 8;
    localparam int INDEX_W  = 5;
    localparam int LEN_W    = 6;
    localparam int STATUS_W = 3;
    localparam int ADDR_W   = 32;
    localparam int OFF_W    = 8;

    // Request kinds.
    localparam logic KIND_NAME   = 1'b0;
    localparam logic KIND_PACKET = 1'b1;

    // Absolute packet offsets ahead of the name.
    localparam logic [OFF_W-1:0] OFF_FLAGS = 8'd2;
    localparam logic [OFF_W-1:0] OFF_LEN   = 8'd12;
    localparam logic [OFF_W-1:0] OFF_NAME  = 8'd13;
    localparam logic [OFF_W-1:0] OFF_MAX   = 8'd255;

    // Offsets counted from the end of the name label.
    localparam logic [OFF_W:0] REL_TYPE    = 9'd7;
    localparam logic [OFF_W:0] REL_TTL     = 9'd11;
    localparam logic [OFF_W:0] REL_DLEN_HI = 9'd15;
    localparam logic [OFF_W:0] REL_DLEN_LO = 9'd16;
    localparam logic [OFF_W:0] REL_ADDR    = 9'd17;
    localparam logic [OFF_W:0] REL_END     = 9'd20;

    // Expected byte values.
    localparam logic [BYTE_W-1:0] FLAGS_VALUE   = 8'h84;
    localparam logic [BYTE_W-1:0] DLEN_HI_VALUE = 8'h00;
    localparam logic [BYTE_W-1:0] DLEN_LO_VALUE = 8'h04;

    // Result status codes.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK     = 3'd0,
        ST_FLAGS  = 3'd1,
        ST_LENGTH = 3'd2,
        ST_NAME   = 3'd3,
        ST_TYPE   = 3'd4,
        ST_DLEN   = 3'd5,
        ST_TRUNC  = 3'd6
    } status_t;

    // Folds an upper-case ASCII letter to lower case.
    function automatic logic [BYTE_W-1:0] fold_case(input logic [BYTE_W-1:0] c);
        if (c >= 8'h41 && c <= 8'h5a) begin
            fold_case = c + 8'h20;
        end else begin
            fold_case = c;
        end
    endfunction

    // The fixed ".local" suffix with its terminating root label.
    function automatic logic [BYTE_W-1:0] suffix_byte(input logic [2:0] idx);
        case (idx)
            3'd0:    suffix_byte = 8'h05;
            3'd1:    suffix_byte = 8'h6c;
            3'd2:    suffix_byte = 8'h6f;
            3'd3:    suffix_byte = 8'h63;
            3'd4:    suffix_byte = 8'h61;
            3'd5:    suffix_byte = 8'h6c;
            default: suffix_byte = 8'h00;
        endcase
    endfunction

    // Type A, class IN with the cache-flush bit.
    function automatic logic [BYTE_W-1:0] type_class_byte(input logic [1:0] idx);
        case (idx)
            2'd0:    type_class_byte = 8'h00;
            2'd1:    type_class_byte = 8'h01;
            2'd2:    type_class_byte = 8'h80;
            default: type_class_byte = 8'h01;
        endcase
    endfunction

endpackage

`default_nettype wire

// ===== rtl/mdns_ipv4_answer_matcher_top.sv =====
// A request is registered on acceptance; the check of a byte is a single compare stage.
// Throughput: one request per cycle; a final byte waits while an unread result is held.
// A name load and a non-final packet byte give no result and never wait on the output.
// Reset clears the offset, the first error, the address, the length register and both
// valid flags; the name store is not cleared and holds whatever was last loaded.
`default_nettype none

module mdns_ipv4_answer_matcher_top (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          cfg_wr_en,
    input  wire [mdnsam_pkg::LEN_W-1:0]  cfg_wr_data,
    input  wire                          s_valid,
    output logic                         s_ready,
    input  wire                          s_kind,
    input  wire [mdnsam_pkg::BYTE_W-1:0] s_byte_value,
    input  wire [mdnsam_pkg::INDEX_W-1:0] s_name_index,
    input  wire                          s_packet_last,
    output logic                         m_valid,
    input  wire                          m_ready,
    output logic [mdnsam_pkg::STATUS_W-1:0] m_status,
    output logic [mdnsam_pkg::ADDR_W-1:0]   m_ipv4_address
);
    import mdnsam_pkg::*;

    // Configuration and packet state.
    logic [LEN_W-1:0]  name_len_reg;
    logic [OFF_W-1:0]  byte_offset_reg, byte_offset_next;
    status_t           first_error_reg, first_error_next;
    logic [ADDR_W-1:0] address_shift_reg, address_shift_next;

    // Name store, loaded before the packet.
    logic [BYTE_W-1:0] name_store [MAX_NAME_BYTES];

    // Input stage.
    logic              in_valid_reg;
    logic              in_kind_reg;
    logic [BYTE_W-1:0] in_byte_reg;
    logic [INDEX_W-1:0] in_index_reg;
    logic              in_last_reg;

    // Result stage.
    logic              out_valid_reg;
    status_t           out_status_reg, out_status_next;
    logic [ADDR_W-1:0] out_addr_reg, out_addr_next;

    // Pipeline control.
    logic is_packet;
    logic makes_result;
    logic advance;

    // Byte check signals.
    logic [OFF_W:0]        off_ext;
    logic [OFF_W:0]        name_end;
    logic                  past_name;
    logic [OFF_W:0]        rel;
    logic [OFF_W:0]        rel_type;
    logic [OFF_W-1:0]      name_pos;
    logic                  name_in_store;
    logic [BYTE_W-1:0]     stored_byte;
    logic [LEN_W:0]        load_index;
    status_t               byte_error;
    logic                  take_address;
    logic                  truncated;

    assign is_packet    = in_kind_reg == KIND_PACKET;
    assign makes_result = in_valid_reg && is_packet && in_last_reg;
    assign advance      = in_valid_reg && !(makes_result && out_valid_reg && !m_ready);
    assign s_ready      = !in_valid_reg || advance;

    // Position of the byte relative to the name label and its suffix.
    assign off_ext       = {1'b0, byte_offset_reg};
    assign name_end      = {1'b0, OFF_NAME} + {{(OFF_W + 1 - LEN_W){1'b0}}, name_len_reg};
    assign past_name     = off_ext >= name_end;
    assign rel           = off_ext - name_end;
    assign rel_type      = rel - REL_TYPE;
    assign name_pos      = byte_offset_reg - OFF_NAME;
    assign name_in_store = name_pos < OFF_W'(MAX_NAME_BYTES);
    assign stored_byte   = name_store[name_pos[NAME_IDX_W-1:0]];
    assign load_index    = {{(LEN_W + 1 - INDEX_W){1'b0}}, in_index_reg};

    // Check of one packet byte against its expected value.
    always_comb begin
        byte_error   = ST_OK;
        take_address = 1'b0;
        if (byte_offset_reg == OFF_FLAGS) begin
            if (in_byte_reg != FLAGS_VALUE) begin
                byte_error = ST_FLAGS;
            end
        end else if (byte_offset_reg == OFF_LEN) begin
            if (in_byte_reg != {{(BYTE_W - LEN_W){1'b0}}, name_len_reg}) begin
                byte_error = ST_LENGTH;
            end
        end else if (byte_offset_reg >= OFF_NAME && !past_name) begin
            if (!name_in_store || fold_case(in_byte_reg) != fold_case(stored_byte)) begin
                byte_error = ST_NAME;
            end
        end else if (past_name && rel < REL_TYPE) begin
            if (fold_case(in_byte_reg) != suffix_byte(rel[2:0])) begin
                byte_error = ST_NAME;
            end
        end else if (past_name && rel >= REL_TYPE && rel < REL_TTL) begin
            if (in_byte_reg != type_class_byte(rel_type[1:0])) begin
                byte_error = ST_TYPE;
            end
        end else if (past_name && rel == REL_DLEN_HI) begin
            if (in_byte_reg != DLEN_HI_VALUE) begin
                byte_error = ST_DLEN;
            end
        end else if (past_name && rel == REL_DLEN_LO) begin
            if (in_byte_reg != DLEN_LO_VALUE) begin
                byte_error = ST_DLEN;
            end
        end else if (past_name && rel >= REL_ADDR && rel <= REL_END) begin
            take_address = 1'b1;
        end
    end

    // The last byte before the final address byte means the packet is short.
    assign truncated = !past_name || rel < REL_END;

    // Next packet state and the result for a final byte.
    always_comb begin
        first_error_next   = (first_error_reg != ST_OK) ? first_error_reg : byte_error;
        address_shift_next = take_address ? {address_shift_reg[ADDR_W-BYTE_W-1:0], in_byte_reg}
                                          : address_shift_reg;
        byte_offset_next   = (byte_offset_reg == OFF_MAX) ? byte_offset_reg
                                                          : byte_offset_reg + 8'd1;
        out_status_next    = first_error_next;
        if (first_error_next == ST_OK && truncated) begin
            out_status_next = ST_TRUNC;
        end
        out_addr_next = (out_status_next == ST_OK) ? address_shift_next : '0;
        if (in_last_reg) begin
            first_error_next   = ST_OK;
            address_shift_next = '0;
            byte_offset_next   = '0;
        end
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            name_len_reg      <= '0;
            byte_offset_reg   <= '0;
            first_error_reg   <= ST_OK;
            address_shift_reg <= '0;
            in_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                name_len_reg <= cfg_wr_data;
            end
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance && is_packet) begin
                byte_offset_reg   <= byte_offset_next;
                first_error_reg   <= first_error_next;
                address_shift_reg <= address_shift_next;
            end
            if (advance && makes_result) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers and the name store.
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_kind_reg  <= s_kind;
            in_byte_reg  <= s_byte_value;
            in_index_reg <= s_name_index;
            in_last_reg  <= s_packet_last;
        end
        if (advance && makes_result) begin
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
        if (advance && !is_packet && load_index < (LEN_W + 1)'(MAX_NAME_BYTES)) begin
            name_store[load_index[NAME_IDX_W-1:0]] <= in_byte_reg;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_status       = out_status_reg;
    assign m_ipv4_address = out_addr_reg;

    // A final byte leaves the packet state cleared for the next packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && makes_result |=> byte_offset_reg == '0 && first_error_reg == ST_OK
                                    && address_shift_reg == '0)
        else $error("packet state not cleared after the final byte");

    // Once a check has failed, the reported failure does not change within the packet.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_packet && !in_last_reg && first_error_reg != ST_OK
        |=> first_error_reg == $past(first_error_reg))
        else $error("first failure overwritten");

    // The byte offset saturates rather than wrapping.
    assert property (@(posedge aclk) disable iff (!aresetn)
        advance && is_packet && !in_last_reg && byte_offset_reg == OFF_MAX
        |=> byte_offset_reg == OFF_MAX)
        else $error("byte offset wrapped");

    // A failed result never carries an address.
    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_status_reg != ST_OK |-> out_addr_reg == '0)
        else $error("address reported with a failure status");

    // A request that gives no result never stalls the input stage.
    assert property (@(posedge aclk) disable iff (!aresetn)
        in_valid_reg && !makes_result |-> advance)
        else $error("non-final request stalled");

endmodule

`default_nettype wire
